/* design/rma_pkg.sv */
// rma_pkg: shared widths and item kind codes for the row-major address unit
// no dependencies; imported by rma_mul and row_major_array_address
`default_nettype none

package rma_pkg;

  localparam int WORD_W = 32;
  localparam int ELEM_W = 16;
  localparam int ID_W   = 4;
  localparam int KIND_W = 2;

  // item kinds on the input beat
  typedef enum logic [KIND_W-1:0] {
    KIND_HEADER = 2'd0,
    KIND_BOUND  = 2'd1,
    KIND_INDEX  = 2'd2,
    KIND_UNUSED = 2'd3
  } kind_t;

endpackage

`default_nettype wire

/* design/row_major_array_address.sv */
// row_major_array_address: descriptor table and row-major address accumulator
// header and bound beats hold busy for the execute step, index beats for execute
//   (ram read) and multiply; a bound beat marked last adds a read, load, multiply and
//   accumulate stride walk step per stored dimension; a new beat is taken only when idle
// done is registered from the multiply step of a last index beat; no receiver stall
// reset (rst, synchronous): fsm idle, dimension counts and running sum cleared
`default_nettype none

module row_major_array_address
  import rma_pkg::*;
#(
  parameter int ARRAYS   = 16,
  parameter int MAX_DIMS = 8
)
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [KIND_W-1:0]        kind,
  input  logic [ID_W-1:0]          array_id,
  input  logic signed [WORD_W-1:0] base_addr,
  input  logic [ELEM_W-1:0]        elem_size,
  input  logic signed [WORD_W-1:0] lower_bound,
  input  logic signed [WORD_W-1:0] upper_bound,
  input  logic signed [WORD_W-1:0] index_value,
  input  logic                     last,
  output logic                     done,
  output logic [ID_W-1:0]          result_array,
  output logic signed [WORD_W-1:0] address
);

  localparam int IW     = (ARRAYS > 1) ? $clog2(ARRAYS) : 1;
  localparam int DW     = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int CW     = $clog2(MAX_DIMS + 1);
  localparam int ADEPTH = 1 << IW;
  localparam int DDEPTH = 1 << (IW + DW);

  typedef struct packed {
    logic [WORD_W-1:0] offset;
    logic [WORD_W-1:0] base;
    logic [ELEM_W-1:0] elem;
    logic [CW-1:0]     count;
  } arr_rec_t;

  typedef struct packed {
    logic [WORD_W-1:0] lower;
    logic [WORD_W-1:0] upper;
    logic [WORD_W-1:0] stride;
  } dim_rec_t;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_EXEC  = 7'b0000010,
    S_IMUL  = 7'b0000100,
    S_WRD   = 7'b0001000,
    S_WLOAD = 7'b0010000,
    S_WMUL  = 7'b0100000,
    S_WACC  = 7'b1000000
  } state_t;

  // array id folded into the descriptor range
  function automatic logic [IW-1:0] id_mod(input logic [ID_W-1:0] raw);
    logic [IW-1:0] r;
    r = '0;
    for (int i = 0; i < (1 << ID_W); i++) begin
      if (raw == ID_W'(i)) r = IW'(i % ARRAYS);
    end
    return r;
  endfunction

  state_t            state;
  kind_t             kind_q;
  logic [IW-1:0]     id_q;
  logic [ID_W-1:0]   raw_q;
  logic [WORD_W-1:0] base_q;
  logic [ELEM_W-1:0] elem_q;
  logic [WORD_W-1:0] lower_in_q;
  logic [WORD_W-1:0] upper_in_q;
  logic [WORD_W-1:0] index_q;
  logic              last_q;

  logic [ADEPTH-1:0] vld;
  logic [CW-1:0]     dim_counter;
  logic [WORD_W-1:0] running_sum;
  logic              use_q;

  logic [DW-1:0]     walk_d;
  logic [WORD_W-1:0] stride_s;
  logic [WORD_W-1:0] c0;
  logic [WORD_W-1:0] lower_q;
  logic [WORD_W-1:0] extent_q;
  arr_rec_t          rec_h;

  arr_rec_t          arr_mem [ADEPTH];
  dim_rec_t          dim_mem [DDEPTH];
  arr_rec_t          arr_rd;
  dim_rec_t          dim_rd;

  logic              accept;
  logic [IW-1:0]     id_in;
  logic [IW-1:0]     arr_ra;
  logic [IW+DW-1:0]  dim_ra;
  logic              arr_we;
  arr_rec_t          arr_wd;
  logic              dim_we;
  logic [IW+DW-1:0]  dim_wa;
  dim_rec_t          dim_wd;

  logic [CW-1:0]     cnt_cur;
  logic              room;
  logic [CW-1:0]     cnt_new;
  logic [WORD_W-1:0] sum_next;

  logic [WORD_W-1:0] mul_a_a;
  logic [WORD_W-1:0] mul_a_b;
  logic [WORD_W-1:0] prod_a;
  logic [WORD_W-1:0] prod_b;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign id_in  = id_mod(array_id);

  // count as stored, zero until the descriptor is first written
  assign cnt_cur = vld[id_q] ? arr_rd.count : '0;
  assign room    = (cnt_cur < CW'(MAX_DIMS));
  assign cnt_new = room ? cnt_cur + CW'(1) : cnt_cur;

  assign sum_next = running_sum + (use_q ? prod_a : '0);

  // multiplier a is shared: index term or stride*lower; multiplier b takes stride*extent
  assign mul_a_a = (state == S_EXEC) ? dim_rd.stride : stride_s;
  assign mul_a_b = (state == S_EXEC) ? index_q : lower_q;

  rma_mul u_mul_a (
    .clk (clk),
    .a   (mul_a_a),
    .b   (mul_a_b),
    .p   (prod_a)
  );

  rma_mul u_mul_b (
    .clk (clk),
    .a   (stride_s),
    .b   (extent_q),
    .p   (prod_b)
  );

  // read addresses: item fields at accept, walk position during the stride walk
  always_comb begin
    arr_ra = (state == S_IDLE) ? id_in : id_q;
    dim_ra = (state == S_IDLE) ? {id_in, dim_counter[DW-1:0]} : {id_q, walk_d};
  end

  // descriptor write-back
  always_comb begin
    arr_we = 1'b0;
    arr_wd = arr_rd;
    if (state == S_EXEC && kind_q == KIND_HEADER) begin
      arr_we = 1'b1;
      arr_wd = '{offset: base_q, base: base_q, elem: elem_q, count: '0};
    end else if (state == S_EXEC && kind_q == KIND_BOUND) begin
      arr_we       = 1'b1;
      arr_wd       = arr_rd;
      arr_wd.count = cnt_new;
    end else if (state == S_WACC && walk_d == '0) begin
      arr_we        = 1'b1;
      arr_wd        = rec_h;
      arr_wd.offset = c0 - prod_a;
    end
  end

  // dimension write: append a bound, or store a stride during the walk
  always_comb begin
    dim_we = 1'b0;
    dim_wa = {id_q, walk_d};
    dim_wd = '{lower: dim_rd.lower, upper: dim_rd.upper, stride: stride_s};
    if (state == S_EXEC && kind_q == KIND_BOUND && room) begin
      dim_we = 1'b1;
      dim_wa = {id_q, cnt_cur[DW-1:0]};
      dim_wd = '{lower: lower_in_q, upper: upper_in_q, stride: '0};
    end else if (state == S_WLOAD) begin
      dim_we = 1'b1;
    end
  end

  // descriptor rams, registered read
  always_ff @(posedge clk) begin
    if (arr_we) arr_mem[id_q] <= arr_wd;
    arr_rd <= arr_mem[arr_ra];
  end

  always_ff @(posedge clk) begin
    if (dim_we) dim_mem[dim_wa] <= dim_wd;
    dim_rd <= dim_mem[dim_ra];
  end

  // captured beat
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_q     <= kind_t'(kind);
      id_q       <= id_in;
      raw_q      <= array_id;
      base_q     <= base_addr;
      elem_q     <= elem_size;
      lower_in_q <= lower_bound;
      upper_in_q <= upper_bound;
      index_q    <= index_value;
      last_q     <= last;
    end
  end

  // walk and result datapath
  always_ff @(posedge clk) begin
    case (state)
      S_EXEC: begin
        if (kind_q == KIND_BOUND) begin
          walk_d   <= DW'(cnt_new - CW'(1));
          stride_s <= {{(WORD_W-ELEM_W){1'b0}}, arr_rd.elem};
          c0       <= arr_rd.base;
          rec_h    <= '{offset: arr_rd.offset, base: arr_rd.base, elem: arr_rd.elem,
                        count: cnt_new};
        end
        use_q <= (dim_counter < cnt_cur) && (dim_counter < CW'(MAX_DIMS));
      end
      S_IMUL: begin
        if (last_q) begin
          address      <= sum_next;
          result_array <= raw_q;
        end
      end
      S_WLOAD: begin
        lower_q  <= dim_rd.lower;
        extent_q <= dim_rd.upper - dim_rd.lower + WORD_W'(1);
      end
      S_WACC: begin
        c0       <= c0 - prod_a;
        stride_s <= prod_b;
        if (walk_d != '0) walk_d <= walk_d - DW'(1);
      end
      default: begin
      end
    endcase
  end

  // control: fsm, valid bits, index run state, result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      vld         <= '0;
      dim_counter <= '0;
      running_sum <= '0;
      done        <= 1'b0;
    end else begin
      done <= 1'b0;
      if (arr_we) vld[id_q] <= 1'b1;
      case (state)
        S_IDLE: begin
          if (accept) state <= S_EXEC;
        end
        S_EXEC: begin
          case (kind_q)
            KIND_BOUND: state <= last_q ? S_WRD : S_IDLE;
            KIND_INDEX: begin
              if (dim_counter == '0) running_sum <= arr_rd.offset;
              state <= S_IMUL;
            end
            default: state <= S_IDLE;
          endcase
        end
        S_IMUL: begin
          if (last_q) begin
            done        <= 1'b1;
            dim_counter <= '0;
            running_sum <= '0;
          end else begin
            running_sum <= sum_next;
            if (dim_counter < CW'(MAX_DIMS)) dim_counter <= dim_counter + CW'(1);
          end
          state <= S_IDLE;
        end
        S_WRD:   state <= S_WLOAD;
        S_WLOAD: state <= S_WMUL;
        S_WMUL:  state <= S_WACC;
        S_WACC:  state <= (walk_d == '0) ? S_IDLE : S_WRD;
        default: state <= S_IDLE;
      endcase
    end
  end

  // a result strobe only follows the accumulate step of an index beat
  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_IMUL))
    else $error("done without a finished index beat");

  // strobe lasts one cycle
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held longer than one cycle");

  // stride walk stays inside the stored dimensions
  a_walk_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_WRD) |-> (CW'(walk_d) < rec_h.count))
    else $error("stride walk beyond dimension count");

  // index position never runs past the dimension limit
  a_dc_range: assert property (@(posedge clk) disable iff (rst)
    dim_counter <= CW'(MAX_DIMS))
    else $error("dimension counter out of range");

  // an accepted beat always goes to the execute step
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_EXEC))
    else $error("accepted beat not executed");

endmodule

`default_nettype wire

/* design/rma_mul.sv */
// rma_mul: registered 32 x 32 multiplier keeping the low word (wraps mod 2^32)
// depends on rma_pkg for the word width
`default_nettype none

module rma_mul
  import rma_pkg::*;
(
  input  logic              clk,
  input  logic [WORD_W-1:0] a,
  input  logic [WORD_W-1:0] b,
  output logic [WORD_W-1:0] p
);

  logic [WORD_W-1:0] full;

  // low word of the product only
  assign full = a * b;

  always_ff @(posedge clk) begin
    p <= full;
  end

endmodule

`default_nettype wire
